### src/ascii_register_response_parser_core_defines.svh
// ============================================================================
// Assertion macros for the ASCII register response parser
// Concurrent assertion wrappers shared by the parser modules.
// ============================================================================
`ifndef ASCII_REGISTER_RESPONSE_PARSER_CORE_DEFINES_SVH
`define ASCII_REGISTER_RESPONSE_PARSER_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define ARP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ARP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ARP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ARP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/arp_pkg.sv
// ============================================================================
// ASCII register response parser package
// Types, character constants and the hex digit decoder.
// ============================================================================
package arp_pkg;

  typedef enum logic {
    KIND_WORD   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  localparam logic [7:0] CHAR_COLON     = 8'h3A;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] HEX_DIGIT_BASE = 8'h30;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;

  // Character positions within the frame, the colon being position zero.
  localparam int unsigned POS_START    = 0;
  localparam int unsigned POS_COUNT_HI = 5;
  localparam int unsigned POS_COUNT_LO = 6;
  localparam int unsigned POS_DATA     = 7;

  localparam int unsigned WORD_BITS  = 16;
  localparam int unsigned TOTAL_BITS = 7;

  // Everything one accepted character produces: an optional data word and
  // an optional end-of-frame status.
  typedef struct packed {
    logic                  has_word;
    logic [WORD_BITS-1:0]  word;
    logic                  has_status;
    logic                  frame_ok;
    logic [TOTAL_BITS-1:0] word_total;
  } bundle_t;

  // Non-hex characters go through the same arithmetic and are not flagged.
  function automatic logic [7:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c < CHAR_COLON) begin
      v = c - HEX_DIGIT_BASE;
    end else begin
      v = c - HEX_ALPHA_BASE;
    end
    return v;
  endfunction

endpackage

### src/arp_channels.sv
// ============================================================================
// ASCII register response parser channels
// Valid/ready interfaces for the character input and the result output.
// ============================================================================
interface arp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       frame_end;

  modport source (output valid, output char_in, output frame_end, input ready);
  modport sink   (input valid, input char_in, input frame_end, output ready);
endinterface

interface arp_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] data_word;
  logic        frame_ok;
  logic [6:0]  word_total;
  logic        run_last;

  modport source (output valid, output result_kind, output data_word,
                  output frame_ok, output word_total, output run_last,
                  input ready);
  modport sink   (input valid, input result_kind, input data_word,
                  input frame_ok, input word_total, input run_last,
                  output ready);
endinterface

### src/arp_decode.sv
// ============================================================================
// ASCII register response parser decoder
// Per-character frame state and hex decoding into words and status.
// ============================================================================
`include "ascii_register_response_parser_core_defines.svh"

module arp_decode #(
  parameter int unsigned POSITION_BITS = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       char_in_i,
  input  logic             frame_end_i,
  output arp_pkg::bundle_t bundle_o,
  output logic             push_o
);
  import arp_pkg::*;

  localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     start_q, start_d;
  logic [7:0]               count_q, count_d;
  logic [3:0]               nib_q, nib_d;
  logic [7:0]               high_q, high_d;
  logic                     phase_q, phase_d;
  logic [TOTAL_BITS-1:0]    words_q, words_d;

  logic [7:0]               hex;
  logic [7:0]               byte_v;
  logic [POSITION_BITS-1:0] data_off;
  logic                     in_data;
  logic                     have_word;

  always_comb begin
    hex      = hex_val(char_in_i);
    byte_v   = {nib_q, 4'b0000} + hex;
    data_off = pos_q - POSITION_BITS'(POS_DATA);
    in_data  = (pos_q >= POSITION_BITS'(POS_DATA)) &&
               (data_off < POSITION_BITS'({count_q, 1'b0}));

    start_d   = start_q;
    count_d   = count_q;
    nib_d     = nib_q;
    high_d    = high_q;
    phase_d   = phase_q;
    words_d   = words_q;
    have_word = 1'b0;

    if (pos_q == POSITION_BITS'(POS_START)) begin
      start_d = (char_in_i == CHAR_COLON);
    end

    if (pos_q == POSITION_BITS'(POS_COUNT_HI)) begin
      nib_d = hex[3:0];
    end else if (pos_q == POSITION_BITS'(POS_COUNT_LO)) begin
      count_d = byte_v;
    end else if (in_data) begin
      if (!data_off[0]) begin
        nib_d = hex[3:0];
      end else if (!phase_q) begin
        high_d  = byte_v;
        phase_d = 1'b1;
      end else begin
        have_word = 1'b1;
        phase_d   = 1'b0;
        words_d   = words_q + 1'b1;
      end
    end

    bundle_o.has_word   = have_word;
    bundle_o.word       = {high_q, byte_v};
    bundle_o.has_status = frame_end_i;
    bundle_o.frame_ok   = start_d && (char_in_i == CHAR_LF) &&
                          (pos_q >= POSITION_BITS'(POS_COUNT_LO));
    bundle_o.word_total = words_d;
    push_o              = accept_i && (have_word || frame_end_i);

    // The final character of a frame returns the parser to its idle state.
    if (frame_end_i) begin
      pos_d   = '0;
      start_d = 1'b0;
      count_d = '0;
      nib_d   = '0;
      high_d  = '0;
      phase_d = 1'b0;
      words_d = '0;
    end else if (pos_q != PosMax) begin
      pos_d = pos_q + 1'b1;
    end else begin
      pos_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      start_q <= 1'b0;
      count_q <= '0;
      nib_q   <= '0;
      high_q  <= '0;
      phase_q <= 1'b0;
      words_q <= '0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      start_q <= start_d;
      count_q <= count_d;
      nib_q   <= nib_d;
      high_q  <= high_d;
      phase_q <= phase_d;
      words_q <= words_d;
    end
  end

  `ARP_ASSERT_IMPLY(a_word_after_header, clk_i, rst_ni,
                    accept_i && have_word, pos_q > POSITION_BITS'(POS_DATA))
  `ARP_ASSERT_NEXT(a_frame_end_rewinds, clk_i, rst_ni,
                   accept_i && frame_end_i, pos_q == '0 && words_q == '0)
  `ARP_ASSERT_IMPLY(a_word_needs_phase, clk_i, rst_ni,
                    accept_i && have_word, phase_q && !phase_d)

endmodule

### src/arp_resq.sv
// ============================================================================
// ASCII register response parser result queue
// Two-entry bundle queue that serializes words and status onto the output.
// ============================================================================
`include "ascii_register_response_parser_core_defines.svh"

module arp_resq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  arp_pkg::bundle_t bundle_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             result_kind_o,
  output logic [15:0]      data_word_o,
  output logic             frame_ok_o,
  output logic [6:0]       word_total_o,
  output logic             run_last_o
);
  import arp_pkg::*;

  bundle_t     slot_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        word_sent_q;

  bundle_t     head;
  logic        emit_word;
  logic        out_fire;
  logic        pop;

  always_comb begin
    head        = slot_q[rd_ptr_q];
    emit_word   = head.has_word && !word_sent_q;
    out_valid_o = (count_q != 2'd0);
    in_ready_o  = (count_q != 2'd2);
    out_fire    = out_valid_o && out_ready_i;

    if (emit_word) begin
      result_kind_o = KIND_WORD;
      data_word_o   = head.word;
      frame_ok_o    = 1'b0;
      word_total_o  = '0;
      run_last_o    = !head.has_status;
    end else begin
      result_kind_o = KIND_STATUS;
      data_word_o   = '0;
      frame_ok_o    = head.frame_ok;
      word_total_o  = head.word_total;
      run_last_o    = 1'b1;
    end

    pop = out_fire && run_last_o;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= 1'b0;
      rd_ptr_q    <= 1'b0;
      count_q     <= 2'd0;
      word_sent_q <= 1'b0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end
      // A word followed by status in the same bundle leaves the bundle
      // in place with its word marked as sent.
      if (pop) begin
        word_sent_q <= 1'b0;
      end else if (out_fire) begin
        word_sent_q <= 1'b1;
      end
    end
  end

  `ARP_ASSERT_IMPLY(a_no_push_when_full, clk_i, rst_ni, push_i, count_q != 2'd2)
  `ARP_ASSERT_IMPLY(a_head_not_empty, clk_i, rst_ni,
                    out_valid_o, head.has_word || head.has_status)
  `ARP_ASSERT_NEXT(a_status_follows_word, clk_i, rst_ni,
                   out_fire && !run_last_o,
                   out_valid_o && result_kind_o == KIND_STATUS)

endmodule

### src/ascii_register_response_parser_core.sv
// A result word is registered in the result queue before it is offered.
// Throughput: one character per cycle while the queue has room; a character that
// completes a data word and also ends the frame yields a word and then a status.
// The two-entry result queue between the decoder and the single output port
// sets this; the input stalls only while that queue is full.
// Reset: rst_ni clears all frame state and the queue at once; no clearing pass.
// ============================================================================
// ASCII register response parser core
// Streams decoded register words and a frame status from ASCII characters.
// ============================================================================
module ascii_register_response_parser_core #(
  parameter int unsigned POSITION_BITS = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  arp_char_if.sink     char_i,
  arp_result_if.source res_o
);
  import arp_pkg::*;

  bundle_t bundle;
  logic    push;
  logic    in_ready;
  logic    accept;

  assign char_i.ready = in_ready;
  assign accept       = char_i.valid && in_ready;

  arp_decode #(
    .POSITION_BITS(POSITION_BITS)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .char_in_i  (char_i.char_in),
    .frame_end_i(char_i.frame_end),
    .bundle_o   (bundle),
    .push_o     (push)
  );

  arp_resq u_resq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .bundle_i     (bundle),
    .in_ready_o   (in_ready),
    .out_valid_o  (res_o.valid),
    .out_ready_i  (res_o.ready),
    .result_kind_o(res_o.result_kind),
    .data_word_o  (res_o.data_word),
    .frame_ok_o   (res_o.frame_ok),
    .word_total_o (res_o.word_total),
    .run_last_o   (res_o.run_last)
  );

endmodule
